// ===== hdl/cdos_pkg.sv =====
package cdos_pkg;

  // Default tick count per delay unit
  localparam int unsigned TICKS_PER_UNIT_DEF = 5;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned UNIT_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF     = 3'd4;

  // Drive modes
  localparam logic [1:0] MODE_LEVEL = 2'd1;
  localparam logic [1:0] MODE_EDGE  = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_DELAY = 2'd1,
    PH_PULSE = 2'd2,
    PH_HOLD  = 2'd3
  } phase_t;

  typedef struct packed {
    logic              enable;
    logic [1:0]        drive_mode;
    logic [UNIT_W-1:0] pre_delay;
    logic [UNIT_W-1:0] pulse_width;
    logic [UNIT_W-1:0] holdoff;
  } cfg_t;

  typedef struct packed {
    logic indicator;
    logic drive_a;
    logic drive_b;
    logic busy_res;
  } res_t;

endpackage

// ===== hdl/cdos_in_reg.sv =====
module cdos_in_reg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [cdos_pkg::SAMPLE_W-1:0] in_sample_p,
  input  logic signed [cdos_pkg::SAMPLE_W-1:0] in_sample_q,
  input  logic                                take,
  output logic                                held_valid,
  output logic signed [cdos_pkg::SAMPLE_W-1:0] held_p,
  output logic signed [cdos_pkg::SAMPLE_W-1:0] held_q
);

  logic                                 vld_r;
  logic signed [cdos_pkg::SAMPLE_W-1:0] p_r;
  logic signed [cdos_pkg::SAMPLE_W-1:0] q_r;

  // free when empty or emptied this cycle
  assign in_ready   = !vld_r || take;
  assign held_valid = vld_r;
  assign held_p     = p_r;
  assign held_q     = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p_r <= in_sample_p;
      q_r <= in_sample_q;
    end
  end

endmodule

// ===== hdl/cdos_core.sv =====
module cdos_core #(
  parameter int unsigned TICKS_PER_UNIT = cdos_pkg::TICKS_PER_UNIT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 step,
  input  cdos_pkg::cfg_t                       cfg,
  input  logic signed [cdos_pkg::SAMPLE_W-1:0] sample_p,
  input  logic signed [cdos_pkg::SAMPLE_W-1:0] sample_q,
  output cdos_pkg::res_t                       res
);

  localparam int unsigned CD_W = $clog2(((1 << cdos_pkg::UNIT_W) - 1) * TICKS_PER_UNIT + 1);

  cdos_pkg::phase_t ph_r, ph_nxt;
  logic [CD_W-1:0]  cd_r, cd_nxt;
  logic             armed_r, armed_nxt;
  logic             ind_r, ind_nxt;
  logic             a_r, a_nxt;
  logic             b_r, b_nxt;

  logic [CD_W-1:0] pre_len, pw_len, hold_len, cd_dec;
  logic            busy, active;
  logic            go_delay, go_pulse, go_rel, go_hold;

  // phase lengths in ticks
  assign pre_len  = CD_W'(32'(cfg.pre_delay) * TICKS_PER_UNIT);
  assign pw_len   = CD_W'(32'(cfg.pulse_width) * TICKS_PER_UNIT);
  assign hold_len = CD_W'(32'(cfg.holdoff) * TICKS_PER_UNIT);

  assign busy   = (ph_r != cdos_pkg::PH_IDLE);
  assign active = (sample_q > sample_p);
  assign cd_dec = (cd_r != '0) ? cd_r - CD_W'(1) : '0;

  always_comb begin
    ph_nxt    = ph_r;
    cd_nxt    = cd_r;
    armed_nxt = armed_r;
    ind_nxt   = ind_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    go_delay  = 1'b0;
    go_pulse  = 1'b0;
    go_rel    = 1'b0;
    go_hold   = 1'b0;

    if (busy) begin
      cd_nxt = cd_dec;
      if (cd_dec == '0) begin
        unique case (ph_r)
          cdos_pkg::PH_DELAY: go_pulse = 1'b1;
          cdos_pkg::PH_PULSE: go_rel   = 1'b1;
          cdos_pkg::PH_HOLD:  ph_nxt   = cdos_pkg::PH_IDLE;
          default:            ph_nxt   = cdos_pkg::PH_IDLE;
        endcase
      end
    end else begin
      ind_nxt = !active;
      if (cfg.enable && cfg.drive_mode == cdos_pkg::MODE_LEVEL) begin
        a_nxt = active;
        b_nxt = !active;
      end
      if (cfg.enable && cfg.drive_mode == cdos_pkg::MODE_EDGE) begin
        if (active) begin
          armed_nxt = 1'b1;
        end else if (armed_r) begin
          go_delay = 1'b1;
        end
      end
      go_hold = !go_delay;
    end

    // zero-length phases fall through within the same tick
    if (go_delay) begin
      cd_nxt = pre_len;
      if (pre_len != '0) ph_nxt = cdos_pkg::PH_DELAY;
      else               go_pulse = 1'b1;
    end
    if (go_pulse) begin
      a_nxt  = 1'b0;
      b_nxt  = 1'b1;
      cd_nxt = pw_len;
      if (pw_len != '0) ph_nxt = cdos_pkg::PH_PULSE;
      else              go_rel = 1'b1;
    end
    if (go_rel) begin
      a_nxt     = 1'b1;
      b_nxt     = 1'b0;
      armed_nxt = 1'b0;
      go_hold   = 1'b1;
    end
    if (go_hold) begin
      cd_nxt = hold_len;
      ph_nxt = (hold_len != '0) ? cdos_pkg::PH_HOLD : cdos_pkg::PH_IDLE;
    end
  end

  assign res.indicator = ind_nxt;
  assign res.drive_a   = a_nxt;
  assign res.drive_b   = b_nxt;
  assign res.busy_res  = busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= cdos_pkg::PH_IDLE;
      cd_r    <= '0;
      armed_r <= 1'b0;
      ind_r   <= 1'b0;
      a_r     <= 1'b0;
      b_r     <= 1'b0;
    end else if (step) begin
      ph_r    <= ph_nxt;
      cd_r    <= cd_nxt;
      armed_r <= armed_nxt;
      ind_r   <= ind_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
    end
  end

endmodule

// ===== hdl/cdos_out_reg.sv =====
module cdos_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load_valid,
  output logic           load_ready,
  input  cdos_pkg::res_t load_res,
  output logic           out_valid,
  input  logic           out_ready,
  output cdos_pkg::res_t out_res
);

  logic           vld_r;
  cdos_pkg::res_t res_r;

  assign load_ready = !vld_r || out_ready;
  assign out_valid  = vld_r;
  assign out_res    = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load_ready) begin
      vld_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      res_r <= load_res;
    end
  end

endmodule

// ===== hdl/comparator_delayed_one_shot_unit.sv =====
// Comparator-triggered delayed one-shot. Each input transfer is one tick carrying
// samples p and q (signed); each tick yields exactly one result transfer with the
// indicator, the two drive levels and a busy flag. Throughput is one tick per
// clock unless out_ready stalls; ticks pass the input register, then the step
// logic feeding the result register. The whole tick update - signed compare,
// countdown decrement and the fall-through of zero-length delay/pulse/holdoff
// phases - is resolved in one pass of combinational logic, so ticks may arrive
// back to back; one more is held while a result waits for out_ready. Delays count in
// units of TICKS_PER_UNIT ticks. Configuration writes are always accepted
// (cfg_ready high out of reset) and should only be made with no tick in flight.
module comparator_delayed_one_shot_unit #(
  parameter int unsigned TICKS_PER_UNIT = cdos_pkg::TICKS_PER_UNIT_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // tick input
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [cdos_pkg::SAMPLE_W-1:0]  in_sample_p,
  input  logic signed [cdos_pkg::SAMPLE_W-1:0]  in_sample_q,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_indicator,
  output logic                                  out_drive_a,
  output logic                                  out_drive_b,
  output logic                                  out_busy_res,
  // register writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cdos_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cdos_pkg::CFG_DATA_W-1:0]       cfg_data
);

  cdos_pkg::cfg_t cfg_r;
  cdos_pkg::res_t step_res;
  cdos_pkg::res_t out_res;

  logic                                 held_valid;
  logic signed [cdos_pkg::SAMPLE_W-1:0] held_p;
  logic signed [cdos_pkg::SAMPLE_W-1:0] held_q;
  logic                                 load_ready;
  logic                                 step;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes beyond the last index are dropped.
  // ---------------------------------------------------------------------------
  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cdos_pkg::CFG_ENABLE:      cfg_r.enable      <= cfg_data[0];
        cdos_pkg::CFG_DRIVE_MODE:  cfg_r.drive_mode  <= cfg_data[1:0];
        cdos_pkg::CFG_PRE_DELAY:   cfg_r.pre_delay   <= cfg_data;
        cdos_pkg::CFG_PULSE_WIDTH: cfg_r.pulse_width <= cfg_data;
        cdos_pkg::CFG_HOLDOFF:     cfg_r.holdoff     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tick register -> step logic -> result register.
  // The state advances exactly when a held tick moves into the result register.
  // ---------------------------------------------------------------------------
  assign step = held_valid && load_ready;

  cdos_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample_p(in_sample_p),
    .in_sample_q(in_sample_q),
    .take       (step),
    .held_valid (held_valid),
    .held_p     (held_p),
    .held_q     (held_q)
  );

  cdos_core #(
    .TICKS_PER_UNIT(TICKS_PER_UNIT)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .cfg     (cfg_r),
    .sample_p(held_p),
    .sample_q(held_q),
    .res     (step_res)
  );

  cdos_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_valid(held_valid),
    .load_ready(load_ready),
    .load_res  (step_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_indicator = out_res.indicator;
  assign out_drive_a   = out_res.drive_a;
  assign out_drive_b   = out_res.drive_b;
  assign out_busy_res  = out_res.busy_res;

endmodule

// ===== hdl/cdos_checker.sv =====
module cdos_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic signed [cdos_pkg::SAMPLE_W-1:0] in_sample_p,
  input logic signed [cdos_pkg::SAMPLE_W-1:0] in_sample_q,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic                                 out_indicator,
  input logic                                 out_drive_a,
  input logic                                 out_drive_b,
  input logic                                 out_busy_res,
  input logic                                 cfg_valid,
  input logic                                 cfg_ready,
  input logic [cdos_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [cdos_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_indicator) &&
      $stable(out_drive_a) && $stable(out_drive_b) && $stable(out_busy_res))
    else $error("result changed while stalled");

  // drive lines are never both high
  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_drive_a && out_drive_b))
    else $error("drive_a and drive_b both high");

  // reset empties the result stage
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // register port never stalls out of reset
  a_cfg_ready: assert property (@(posedge clk)
    rst_n |-> cfg_ready)
    else $error("cfg_ready low out of reset");

endmodule

bind comparator_delayed_one_shot_unit cdos_checker u_cdos_checker (.*);
